@@ sv/psc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the path segment to control points unit.
// No dependencies; every other file of the unit imports this package.
package psc_pkg;

  // Width of each coordinate field on the ports (Q16.16).
  localparam int PT_W = 32;

  // Default internal coordinate width and command queue depth.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Segment commands, coded as on the input port.
  typedef enum logic [3:0] {
    OP_MOVE   = 4'd0,
    OP_LINE   = 4'd1,
    OP_HORIZ  = 4'd2,
    OP_VERT   = 4'd3,
    OP_QUAD   = 4'd4,
    OP_SQUAD  = 4'd5,
    OP_CUBIC  = 4'd6,
    OP_SCUBIC = 4'd7,
    OP_CLOSE  = 4'd8
  } op_t;

  // Kind of the previous segment, which tags the reflection point.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_QUAD  = 2'd1,
    KIND_CUBIC = 2'd2
  } kind_t;

  // Role of an emitted point.
  typedef enum logic [1:0] {
    ROLE_END  = 2'd0,
    ROLE_CTL1 = 2'd1,
    ROLE_CTL2 = 2'd2
  } role_t;

  // Where the coordinates of an emitted point come from.
  typedef enum logic [2:0] {
    SRC_SUM,
    SRC_HORIZ,
    SRC_VERT,
    SRC_SMOOTH,
    SRC_START
  } src_t;

  // Command part of a queued word; coordinates travel beside it.
  typedef struct packed {
    op_t  op;
    logic rel;
  } cmd_t;

  // Per-point control decoded from command and step.
  typedef struct packed {
    logic [1:0] pair;
    src_t       src;
    role_t      role;
    logic       last;
  } step_ctl_t;

  // Input word.
  typedef struct packed {
    logic [3:0]             action;
    logic                   relative;
    logic signed [PT_W-1:0] coord_a;
    logic signed [PT_W-1:0] coord_b;
    logic signed [PT_W-1:0] coord_c;
    logic signed [PT_W-1:0] coord_d;
    logic signed [PT_W-1:0] coord_e;
    logic signed [PT_W-1:0] coord_f;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic [1:0]             point_role;
    logic                   last_point;
  } out_word_t;

endpackage

@@ sv/psc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input words, drops unknown commands and clamps coordinates.
// Depends on psc_pkg; feeds psc_queue.
module psc_front #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  psc_pkg::in_word_t                      in_word,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [$bits(psc_pkg::cmd_t)+6*COORD_WIDTH-1:0] q_data
);
  import psc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int EW = (W > PT_W) ? W : PT_W;

  // Bring a port coordinate to the internal width, saturating when narrower.
  function automatic logic signed [W-1:0] take(input logic signed [PT_W-1:0] x);
    logic signed [W-1:0]  maxw;
    logic signed [W-1:0]  minw;
    logic signed [EW-1:0] e;
    maxw = {1'b0, {(W-1){1'b1}}};
    minw = {1'b1, {(W-1){1'b0}}};
    e    = EW'(x);
    if (e > EW'(maxw)) begin
      take = maxw;
    end else if (e < EW'(minw)) begin
      take = minw;
    end else begin
      take = e[W-1:0];
    end
  endfunction

  logic known;
  cmd_t cmd;

  // Only the nine defined commands go on; others are taken and dropped.
  always_comb begin
    known = (in_word.action <= OP_CLOSE);
    cmd.op  = op_t'(in_word.action);
    cmd.rel = in_word.relative;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;

  assign q_data = {cmd,
                   take(in_word.coord_f), take(in_word.coord_e),
                   take(in_word.coord_d), take(in_word.coord_c),
                   take(in_word.coord_b), take(in_word.coord_a)};

endmodule

@@ sv/psc_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the point generator.
// Depends on psc_pkg only for the default depth; generic in width.
module psc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = psc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data
);
  import psc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = entry_r[rd_ptr_r];

  // Pointer and fill-count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count above depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> count_r == CW'(DEPTH))
    else $error("queue lost a word while full");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

@@ sv/psc_back.sv @@
`timescale 1ns / 1ps
// Point generator: holds the path state and emits one absolute point per cycle while the output is not stalled.
// Depends on psc_pkg; takes commands from psc_queue.
module psc_back #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  logic [$bits(psc_pkg::cmd_t)+6*COORD_WIDTH-1:0] q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output psc_pkg::out_word_t                     out_word
);
  import psc_pkg::*;

  localparam int W = COORD_WIDTH;

  // Saturating add of two W-bit values.
  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sadd = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sadd = s[W-1:0];
    end
  endfunction

  // Saturating reflection 2*e - c.
  function automatic logic signed [W-1:0] refl(input logic signed [W-1:0] e,
                                               input logic signed [W-1:0] c);
    logic signed [W+1:0] r;
    r = {e[W-1], e, 1'b0} - {{2{c[W-1]}}, c};
    if (r[W+1:W-1] != '0 && r[W+1:W-1] != '1) begin
      refl = r[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      refl = r[W-1:0];
    end
  endfunction

  // Decode of one step of a command: operand pair, source, role, last flag.
  function automatic step_ctl_t decode(input op_t op, input logic [1:0] step);
    step_ctl_t d;
    d.pair = 2'd0;
    d.src  = SRC_SUM;
    d.role = ROLE_END;
    d.last = 1'b1;
    unique case (op) inside
      OP_MOVE, OP_LINE: begin
      end
      OP_HORIZ: begin
        d.src = SRC_HORIZ;
      end
      OP_VERT: begin
        d.src = SRC_VERT;
      end
      OP_QUAD: begin
        if (step == 2'd0) begin
          d.role = ROLE_CTL1;
          d.last = 1'b0;
        end else begin
          d.pair = 2'd1;
        end
      end
      OP_SQUAD: begin
        if (step == 2'd0) begin
          d.src  = SRC_SMOOTH;
          d.role = ROLE_CTL1;
          d.last = 1'b0;
        end
      end
      OP_CUBIC: begin
        if (step == 2'd0) begin
          d.role = ROLE_CTL1;
          d.last = 1'b0;
        end else if (step == 2'd1) begin
          d.pair = 2'd1;
          d.role = ROLE_CTL2;
          d.last = 1'b0;
        end else begin
          d.pair = 2'd2;
        end
      end
      OP_SCUBIC: begin
        if (step == 2'd0) begin
          d.src  = SRC_SMOOTH;
          d.role = ROLE_CTL1;
          d.last = 1'b0;
        end else if (step == 2'd1) begin
          d.role = ROLE_CTL2;
          d.last = 1'b0;
        end else begin
          d.pair = 2'd1;
        end
      end
      OP_CLOSE: begin
        d.src = SRC_START;
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  // Command being worked on.
  cmd_t                cmd_r, cmd_nxt;
  logic signed [W-1:0] v_r [6];
  logic signed [W-1:0] v_nxt [6];
  logic                busy_r, busy_nxt;
  logic [1:0]          step_r, step_nxt;

  // Path state.
  logic signed [W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [W-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic signed [W-1:0] refl_x_r, refl_x_nxt, refl_y_r, refl_y_nxt;
  logic signed [W-1:0] ctl_x_r, ctl_x_nxt, ctl_y_r, ctl_y_nxt;
  kind_t               kind_r, kind_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  step_ctl_t           ctl;
  logic                out_free;
  logic                emit;
  logic                done;
  logic                smooth_hit;
  logic signed [W-1:0] ox, oy, opx, opy, sx, sy, pt_x, pt_y, rx, ry;

  // Step decode and handshake with the queue and the output register.
  always_comb begin
    ctl      = decode(cmd_r.op, step_r);
    out_free = !out_valid_r || !out_stall;
    emit     = busy_r && out_free;
    done     = emit && ctl.last;
    q_pop    = q_valid && (!busy_r || done);
  end

  // Point arithmetic for the current step.
  always_comb begin
    ox = cmd_r.rel ? cur_x_r : '0;
    oy = cmd_r.rel ? cur_y_r : '0;
    case (ctl.pair)
      2'd0: begin
        opx = v_r[0];
        opy = v_r[1];
      end
      2'd1: begin
        opx = v_r[2];
        opy = v_r[3];
      end
      default: begin
        opx = v_r[4];
        opy = v_r[5];
      end
    endcase
    // A vertical segment carries its lone value in the first coordinate.
    if (ctl.src == SRC_VERT) begin
      opy = v_r[0];
    end
    sx = sadd(ox, opx);
    sy = sadd(oy, opy);
    smooth_hit = (cmd_r.op == OP_SQUAD && kind_r == KIND_QUAD) ||
                 (cmd_r.op == OP_SCUBIC && kind_r == KIND_CUBIC);
    unique case (ctl.src)
      SRC_SUM: begin
        pt_x = sx;
        pt_y = sy;
      end
      SRC_HORIZ: begin
        pt_x = sx;
        pt_y = cur_y_r;
      end
      SRC_VERT: begin
        pt_x = cur_x_r;
        pt_y = sy;
      end
      SRC_SMOOTH: begin
        pt_x = smooth_hit ? refl_x_r : cur_x_r;
        pt_y = smooth_hit ? refl_y_r : cur_y_r;
      end
      SRC_START: begin
        pt_x = start_x_r;
        pt_y = start_y_r;
      end
      default: begin
        pt_x = sx;
        pt_y = sy;
      end
    endcase
    rx = refl(pt_x, ctl_x_r);
    ry = refl(pt_y, ctl_y_r);
  end

  // Next-state logic for the sequencer, path state and output register.
  always_comb begin
    cmd_nxt       = cmd_r;
    v_nxt         = v_r;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    refl_x_nxt    = refl_x_r;
    refl_y_nxt    = refl_y_r;
    ctl_x_nxt     = ctl_x_r;
    ctl_y_nxt     = ctl_y_r;
    kind_nxt      = kind_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_word_nxt.point_x    = PT_W'(pt_x);
      out_word_nxt.point_y    = PT_W'(pt_y);
      out_word_nxt.point_role = ctl.role;
      out_word_nxt.last_point = ctl.last;
      step_nxt                = step_r + 1'b1;
      if (ctl.role != ROLE_END) begin
        ctl_x_nxt = pt_x;
        ctl_y_nxt = pt_y;
      end
    end

    // The end point commits the segment to the path state.
    if (done) begin
      busy_nxt  = 1'b0;
      cur_x_nxt = pt_x;
      cur_y_nxt = pt_y;
      unique case (cmd_r.op) inside
        OP_QUAD, OP_SQUAD: begin
          refl_x_nxt = rx;
          refl_y_nxt = ry;
          kind_nxt   = KIND_QUAD;
        end
        OP_CUBIC, OP_SCUBIC: begin
          refl_x_nxt = rx;
          refl_y_nxt = ry;
          kind_nxt   = KIND_CUBIC;
        end
        default: begin
          refl_x_nxt = pt_x;
          refl_y_nxt = pt_y;
          kind_nxt   = KIND_NONE;
        end
      endcase
      if (cmd_r.op == OP_MOVE) begin
        start_x_nxt = pt_x;
        start_y_nxt = pt_y;
      end
    end

    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      cmd_nxt  = q_data[$bits(cmd_t)+6*W-1 -: $bits(cmd_t)];
      for (int i = 0; i < 6; i++) begin
        v_nxt[i] = q_data[i*W +: W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      refl_x_r    <= '0;
      refl_y_r    <= '0;
      kind_r      <= KIND_NONE;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      refl_x_r    <= refl_x_nxt;
      refl_y_r    <= refl_y_nxt;
      kind_r      <= kind_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    v_r        <= v_nxt;
    ctl_x_r    <= ctl_x_nxt;
    ctl_y_r    <= ctl_y_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r != 2'd3)
    else $error("point step ran past the third point");

  a_refl_plain: assert property (@(posedge clk) disable iff (!rst_n)
    kind_r == KIND_NONE |-> refl_x_r == cur_x_r && refl_y_r == cur_y_r)
    else $error("reflection point differs from current point after a plain segment");

  a_more_points: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !ctl.last |=> busy_r && step_r != 2'd0)
    else $error("segment dropped before its end point");

  a_close_returns: assert property (@(posedge clk) disable iff (!rst_n)
    done && cmd_r.op == OP_CLOSE |=> cur_x_r == start_x_r && cur_y_r == start_y_r)
    else $error("close did not return to the subpath start");

endmodule

@@ sv/path_segment_to_control_points_unit.sv @@
`timescale 1ns / 1ps
// Path segment to control points: turns path segments into absolute points.
// A taken word reaches its first point via the queue, command and output registers.
// Throughput: one point per cycle leaves the output register while out_stall is low: one
// point for move, line, horizontal, vertical and close, two for quadratics, three for cubics.
// A command queue, two words deep by default, decouples intake from the point generator.
// Reset (rst_n low, synchronous) clears the path state to zero and empties the queue.
module path_segment_to_control_points_unit #(
  parameter int COORD_WIDTH = psc_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = psc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output psc_pkg::out_word_t out_word
);
  import psc_pkg::*;

  localparam int QW = $bits(cmd_t) + 6 * COORD_WIDTH;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  logic [QW-1:0] q_in_data;
  logic [QW-1:0] q_head_data;

  psc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in_data)
  );

  psc_queue #(
    .DATA_W(QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head_data)
  );

  psc_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_head_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
